// ===== rtl/tlnc_pkg.sv =====
// shared types and constants for the name cache
package tlnc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned ADDR_W = 32;
  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam logic [31:0] TTL_FLOOR_RST = 32'd60;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_FLUSH  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_META,
    ST_FIND_CMP,
    ST_HIT,
    ST_PURGE,
    ST_LRU,
    ST_NEW,
    ST_COPY,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/ttl_lru_name_cache_unit.sv =====
// name-keyed address cache with expiry and lru replacement
//
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata name/addr/ttl/now, tuser func, tlast
// out_    | out | out_tvalid/out_tready| tdata addr_out, tuser found
// cfg_    | in  | cfg_we               | cfg_wdata ttl floor in seconds
//
// a byte word without tlast only adds its byte to the key; the last word runs the operation
// on one shared compare unit stepping one slot or one name byte per cycle:
// lookup scans the slots and the matched name bytes; insert of a new name adds
// the purge sweep, the lru ranking over all slots when full, and the name copy
// of the key bytes; flush and unused codes go straight to the result word
// in_tready is low from the last word until the result word is taken
// synchronous active-low reset clears valid bits and counters and sets the ttl floor to TTL_FLOOR_RST
module ttl_lru_name_cache_unit #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned NAME_LEN = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // name_byte[7:0], addr_value[39:8], ttl_s[71:40], now_ms[103:72]
  input  logic [1:0]   in_tuser,   // func[1:0]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // addr_out[31:0]
  output logic         out_tuser,  // found[0]
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  localparam int unsigned SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KW  = $clog2(NAME_LEN);
  localparam int unsigned RW  = $clog2(ENTRIES + 1);
  localparam int unsigned NAW = (ENTRIES * NAME_LEN > 1) ? $clog2(ENTRIES * NAME_LEN) : 1;
  localparam int unsigned TW  = tlnc_pkg::TIME_W;

  typedef struct packed {
    logic [KW-1:0] len;
    logic [31:0]   addr;
    logic [TW-1:0] expire;
    logic [TW-1:0] last_use;
    logic [31:0]   stamp;
  } meta_t;

  // storage
  meta_t      meta_mem [ENTRIES];
  logic [7:0] name_mem [ENTRIES*NAME_LEN];
  logic [7:0] key_mem  [NAME_LEN];
  meta_t      meta_q;
  logic [7:0] nm_q, kb_q;

  tlnc_pkg::state_t state_r, state_nxt;
  tlnc_pkg::func_t  func_r, func_nxt;
  logic [SW-1:0]    slot_r, slot_nxt, free_r, free_nxt;
  logic [KW-1:0]    byte_r, byte_nxt, klen_r, klen_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [TW-1:0]    exp_r, exp_nxt, now_r, now_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]      cnt_r, cnt_nxt, floor_r, floor_nxt;
  logic             have_free_r, have_free_nxt;
  logic             cand_have_r, cand_have_nxt;
  logic [SW-1:0]    cand_slot_r, cand_slot_nxt, prev_slot_r, prev_slot_nxt;
  logic [SW-1:0]    best_slot_r, best_slot_nxt;
  logic [31:0]      cand_age_r, cand_age_nxt, prev_age_r, prev_age_nxt;
  logic [TW-1:0]    cand_lu_r, cand_lu_nxt, best_lu_r, best_lu_nxt;
  logic [RW-1:0]    round_r, round_nxt;
  logic             found_r, found_nxt;
  logic [31:0]      oaddr_r, oaddr_nxt;

  logic             meta_we, nm_we, key_we;
  logic [SW-1:0]    meta_wa;
  meta_t            meta_wd;
  logic [NAW-1:0]   nm_wa, nm_ra;
  logic [7:0]       key_wd;

  logic             in_acc, last_slot, slot_match, expired;
  logic [7:0]       in_byte, fold_byte;
  logic [31:0]      eff_ttl, age;
  logic [31:0]      ttl_ms;
  logic             after_prev, better;
  logic [SW-1:0]    fin_slot;
  logic [31:0]      fin_age;
  logic [TW-1:0]    fin_lu;

  assign in_acc    = in_tvalid && in_tready;
  assign in_byte   = in_tdata[7:0];
  assign fold_byte = (in_byte >= tlnc_pkg::CHAR_UP_A && in_byte <= tlnc_pkg::CHAR_UP_Z) ?
                     in_byte + tlnc_pkg::CASE_OFS : in_byte;
  assign eff_ttl   = (in_tdata[71:40] < floor_r) ? floor_r : in_tdata[71:40];
  assign ttl_ms    = eff_ttl * tlnc_pkg::MS_PER_S;
  assign last_slot = (slot_r == SW'(ENTRIES - 1));
  assign slot_match = valid_r[slot_r] && (meta_q.len == klen_r);
  assign expired   = !(now_r - meta_q.expire >= 32'h8000_0000);
  assign age       = cnt_r - meta_q.stamp;

  assign nm_ra = NAW'(slot_nxt) * NAW'(NAME_LEN) + NAW'(byte_nxt);
  assign nm_wa = NAW'(free_r) * NAW'(NAME_LEN) + NAW'(byte_r);

  assign out_tdata = oaddr_r;
  assign out_tuser = found_r;

  always_comb begin
    state_nxt = state_r;  func_nxt = func_r;  slot_nxt = slot_r;  free_nxt = free_r;
    byte_nxt = byte_r;  klen_nxt = klen_r;  addr_nxt = addr_r;  exp_nxt = exp_r;
    now_nxt = now_r;  valid_nxt = valid_r;  cnt_nxt = cnt_r;
    floor_nxt = cfg_we ? cfg_wdata : floor_r;
    have_free_nxt = have_free_r;  cand_have_nxt = cand_have_r;
    cand_slot_nxt = cand_slot_r;  cand_age_nxt = cand_age_r;  cand_lu_nxt = cand_lu_r;
    prev_slot_nxt = prev_slot_r;  prev_age_nxt = prev_age_r;
    best_slot_nxt = best_slot_r;  best_lu_nxt = best_lu_r;  round_nxt = round_r;
    found_nxt = found_r;  oaddr_nxt = oaddr_r;
    in_tready = 1'b0;  out_tvalid = 1'b0;
    meta_we = 1'b0;  meta_wa = slot_r;  meta_wd = meta_q;
    nm_we = 1'b0;  key_we = 1'b0;  key_wd = fold_byte;
    after_prev = 1'b0;  better = 1'b0;
    fin_slot = cand_slot_r;  fin_age = cand_age_r;  fin_lu = cand_lu_r;
    unique case (state_r)
      tlnc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (in_byte != 8'd0 && klen_r < KW'(NAME_LEN - 1)) begin
            key_we   = 1'b1;
            klen_nxt = klen_r + KW'(1);
          end
          if (in_tlast) begin
            func_nxt  = tlnc_pkg::func_t'(in_tuser);
            addr_nxt  = in_tdata[39:8];
            now_nxt   = in_tdata[103:72];
            exp_nxt   = in_tdata[103:72] + ttl_ms;
            slot_nxt  = '0;
            found_nxt = 1'b0;
            oaddr_nxt = '0;
            case (tlnc_pkg::func_t'(in_tuser)) inside
              tlnc_pkg::FN_LOOKUP, tlnc_pkg::FN_INSERT: state_nxt = tlnc_pkg::ST_FIND_META;
              tlnc_pkg::FN_FLUSH: begin
                valid_nxt = '0;
                state_nxt = tlnc_pkg::ST_DONE;
              end
              default: state_nxt = tlnc_pkg::ST_DONE;
            endcase
          end
        end
      end
      tlnc_pkg::ST_FIND_META, tlnc_pkg::ST_FIND_CMP: begin
        if (state_r == tlnc_pkg::ST_FIND_META ? slot_match : (nm_q == kb_q)) begin
          if (state_r == tlnc_pkg::ST_FIND_META) begin
            byte_nxt = '0;
            state_nxt = (klen_r == '0) ? tlnc_pkg::ST_HIT : tlnc_pkg::ST_FIND_CMP;
          end else if (byte_r == klen_r - KW'(1)) begin
            state_nxt = tlnc_pkg::ST_HIT;
          end else begin
            byte_nxt = byte_r + KW'(1);
          end
        end else if (last_slot) begin
          // no match anywhere
          slot_nxt = '0;
          have_free_nxt = 1'b0;
          state_nxt = (func_r == tlnc_pkg::FN_INSERT) ? tlnc_pkg::ST_PURGE : tlnc_pkg::ST_DONE;
        end else begin
          slot_nxt  = slot_r + SW'(1);
          state_nxt = tlnc_pkg::ST_FIND_META;
        end
      end
      tlnc_pkg::ST_HIT: begin
        state_nxt = tlnc_pkg::ST_DONE;
        if (func_r == tlnc_pkg::FN_INSERT) begin
          meta_we = 1'b1;
          meta_wd.addr = addr_r;
          meta_wd.expire = exp_r;
          meta_wd.last_use = now_r;
          found_nxt = 1'b1;
        end else if (!expired) begin
          meta_we = 1'b1;
          meta_wd.last_use = now_r;
          found_nxt = 1'b1;
          oaddr_nxt = meta_q.addr;
        end
      end
      tlnc_pkg::ST_PURGE: begin
        if (valid_r[slot_r] && expired) valid_nxt[slot_r] = 1'b0;
        if (!valid_nxt[slot_r] && !have_free_r) begin
          free_nxt = slot_r;
          have_free_nxt = 1'b1;
        end
        if (last_slot) begin
          slot_nxt = '0;
          round_nxt = '0;
          cand_have_nxt = 1'b0;
          state_nxt = have_free_nxt ? tlnc_pkg::ST_NEW : tlnc_pkg::ST_LRU;
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      tlnc_pkg::ST_LRU: begin
        // each round picks the next slot in oldest-inserted order
        after_prev = (round_r == '0) || (age < prev_age_r) ||
                     (age == prev_age_r && slot_r > prev_slot_r);
        better = !cand_have_r || (age > cand_age_r) ||
                 (age == cand_age_r && slot_r < cand_slot_r);
        if (after_prev && better) begin
          fin_slot = slot_r;
          fin_age  = age;
          fin_lu   = meta_q.last_use;
          cand_have_nxt = 1'b1;
        end
        cand_slot_nxt = fin_slot;  cand_age_nxt = fin_age;  cand_lu_nxt = fin_lu;
        if (last_slot) begin
          slot_nxt = '0;
          cand_have_nxt = 1'b0;
          prev_slot_nxt = fin_slot;
          prev_age_nxt = fin_age;
          if (round_r == '0 || (fin_lu - best_lu_r >= 32'h8000_0000)) begin
            best_slot_nxt = fin_slot;
            best_lu_nxt = fin_lu;
          end
          round_nxt = round_r + RW'(1);
          if (round_r == RW'(ENTRIES - 1)) begin
            free_nxt  = best_slot_nxt;
            state_nxt = tlnc_pkg::ST_NEW;
          end
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      tlnc_pkg::ST_NEW: begin
        meta_we = 1'b1;
        meta_wa = free_r;
        meta_wd.len = klen_r;
        meta_wd.addr = addr_r;
        meta_wd.expire = exp_r;
        meta_wd.last_use = now_r;
        meta_wd.stamp = cnt_r;
        cnt_nxt = cnt_r + 32'd1;
        valid_nxt[free_r] = 1'b1;
        byte_nxt = '0;
        state_nxt = (klen_r == '0) ? tlnc_pkg::ST_DONE : tlnc_pkg::ST_COPY;
      end
      tlnc_pkg::ST_COPY: begin
        nm_we = 1'b1;
        if (byte_r == klen_r - KW'(1)) state_nxt = tlnc_pkg::ST_DONE;
        else byte_nxt = byte_r + KW'(1);
      end
      tlnc_pkg::ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          klen_nxt  = '0;
          state_nxt = tlnc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlnc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlnc_pkg::ST_IDLE;
      klen_r  <= '0;
      valid_r <= '0;
      cnt_r   <= '0;
      floor_r <= tlnc_pkg::TTL_FLOOR_RST;
    end else begin
      state_r <= state_nxt;
      klen_r  <= klen_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      floor_r <= floor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;  slot_r <= slot_nxt;  free_r <= free_nxt;  byte_r <= byte_nxt;
    addr_r <= addr_nxt;  exp_r <= exp_nxt;  now_r <= now_nxt;
    have_free_r <= have_free_nxt;  cand_have_r <= cand_have_nxt;
    cand_slot_r <= cand_slot_nxt;  cand_age_r <= cand_age_nxt;  cand_lu_r <= cand_lu_nxt;
    prev_slot_r <= prev_slot_nxt;  prev_age_r <= prev_age_nxt;
    best_slot_r <= best_slot_nxt;  best_lu_r <= best_lu_nxt;  round_r <= round_nxt;
    found_r <= found_nxt;  oaddr_r <= oaddr_nxt;
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_q <= meta_mem[slot_nxt];
  end

  always_ff @(posedge clk) begin
    if (nm_we) name_mem[nm_wa] <= kb_q;
    nm_q <= name_mem[nm_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[klen_r] <= key_wd;
    kb_q <= key_mem[byte_nxt];
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while result pending");

  a_klen_range: assert property (@(posedge clk) disable iff (!rst_n)
    klen_r <= KW'(NAME_LEN - 1)) else $error("key length overflow");

  a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tlnc_pkg::ST_COPY |-> byte_r < klen_r) else $error("copy past key end");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && klen_r == '0) else $error("no return to idle");

endmodule

// ===== bench/ttl_lru_name_cache_unit_tb.sv =====
// testbench for the ttl/lru name cache: random name streams checked against a scoreboard
`timescale 1ns / 100ps

module ttl_lru_name_cache_unit_tb;

  localparam int unsigned N_SLOTS = 32;
  localparam int unsigned KEY_MAX = 64;
  localparam int unsigned N_NAMES = 48;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned LONG_HOLD = 400;

  class name_cache_scoreboard;
    logic [31:0] ttl_floor;
    bit          valid_q [N_SLOTS];
    logic [7:0]  name_q [N_SLOTS][KEY_MAX];
    int          name_len_q [N_SLOTS];
    logic [31:0] addr_q [N_SLOTS];
    logic [31:0] expiry_q [N_SLOTS];
    logic [31:0] used_q [N_SLOTS];
    logic [31:0] stamp_q [N_SLOTS];
    logic [31:0] insert_cnt;
    logic [7:0]  key_q [KEY_MAX];
    int          key_len;
    bit          want_found [$];
    logic [31:0] want_addr [$];
    int          mismatches;

    function new();
      ttl_floor = tlnc_pkg::TTL_FLOOR_RST;
      insert_cnt = '0;
      key_len = 0;
      mismatches = 0;
      foreach (valid_q[s]) valid_q[s] = 1'b0;
    endfunction

    function bit earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function bit stale(int s, logic [31:0] now);
      return !earlier(now, expiry_q[s]);
    endfunction

    function int find_slot();
      bit same;
      for (int s = 0; s < N_SLOTS; s++) begin
        if (valid_q[s] && name_len_q[s] == key_len) begin
          same = 1'b1;
          for (int i = 0; i < key_len; i++)
            if (name_q[s][i] != key_q[i]) same = 1'b0;
          if (same) return s;
        end
      end
      return -1;
    endfunction

    // the one used longest ago wins; among equal use times the oldest insertion wins
    function int pick_victim();
      int rank [N_SLOTS];
      int n;
      int k;
      int best;
      logic [31:0] age;
      n = 0;
      for (int s = 0; s < N_SLOTS; s++) begin
        if (valid_q[s]) begin
          age = insert_cnt - stamp_q[s];
          k = n;
          while (k > 0 && (insert_cnt - stamp_q[rank[k-1]]) < age) begin
            rank[k] = rank[k-1];
            k--;
          end
          rank[k] = s;
          n++;
        end
      end
      if (n == 0) return -1;
      best = rank[0];
      for (int i = 1; i < n; i++)
        if (earlier(used_q[rank[i]], used_q[best])) best = rank[i];
      return best;
    endfunction

    function bit store_name(logic [31:0] addr, logic [31:0] ttl, logic [31:0] now);
      logic [31:0] lifetime;
      logic [31:0] exp_at;
      int s;
      lifetime = (ttl < ttl_floor) ? ttl_floor : ttl;
      exp_at = now + lifetime * tlnc_pkg::MS_PER_S;
      s = find_slot();
      if (s >= 0) begin
        addr_q[s] = addr;
        expiry_q[s] = exp_at;
        used_q[s] = now;
        return 1'b1;
      end
      for (int i = 0; i < N_SLOTS; i++)
        if (valid_q[i] && stale(i, now)) valid_q[i] = 1'b0;
      s = -1;
      for (int i = 0; i < N_SLOTS; i++)
        if (!valid_q[i] && s < 0) s = i;
      if (s < 0) begin
        s = pick_victim();
        if (s < 0) s = 0;
      end
      for (int i = 0; i < key_len; i++) name_q[s][i] = key_q[i];
      name_len_q[s] = key_len;
      addr_q[s] = addr;
      expiry_q[s] = exp_at;
      used_q[s] = now;
      stamp_q[s] = insert_cnt;
      insert_cnt++;
      valid_q[s] = 1'b1;
      return 1'b0;
    endfunction

    function void note_word(tlnc_pkg::func_t fn, logic [7:0] b, bit last, logic [31:0] addr,
                            logic [31:0] ttl, logic [31:0] now);
      bit          hit;
      logic [31:0] res_addr;
      int          s;
      if (b != 8'd0 && key_len < KEY_MAX - 1) begin
        key_q[key_len] = (b >= tlnc_pkg::CHAR_UP_A && b <= tlnc_pkg::CHAR_UP_Z) ?
                         b + tlnc_pkg::CASE_OFS : b;
        key_len++;
      end
      if (!last) return;
      hit = 1'b0;
      res_addr = '0;
      case (fn)
        tlnc_pkg::FN_LOOKUP: begin
          s = find_slot();
          if (s >= 0 && !stale(s, now)) begin
            used_q[s] = now;
            hit = 1'b1;
            res_addr = addr_q[s];
          end
        end
        tlnc_pkg::FN_INSERT: hit = store_name(addr, ttl, now);
        tlnc_pkg::FN_FLUSH: foreach (valid_q[i]) valid_q[i] = 1'b0;
        default: ;
      endcase
      key_len = 0;
      want_found = {want_found, hit};
      want_addr = {want_addr, res_addr};
    endfunction

    function void check_result(bit found, logic [31:0] addr);
      bit          e_found;
      logic [31:0] e_addr;
      if (want_found.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word found=%0b addr=%08h", found, addr);
        return;
      end
      e_found = want_found.pop_front();
      e_addr = want_addr.pop_front();
      if (found !== e_found || addr !== e_addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected found=%0b addr=%08h, got found=%0b addr=%08h",
                   e_found, e_addr, found, addr);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // name_byte[7:0], addr_value[39:8], ttl_s[71:40], now_ms[103:72]
  logic [1:0]   in_tuser;   // func[1:0]
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;  // addr_out[31:0]
  logic         out_tuser;  // found[0]
  logic         cfg_we;
  logic [31:0]  cfg_wdata;

  ttl_lru_name_cache_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  name_cache_scoreboard sb;
  bit          quiet;
  int          hold_reqs = 0;
  int          idle_cycles = 0;
  logic [31:0] now_ms;
  logic [7:0]  names [N_NAMES][72];
  int          name_len [N_NAMES];
  string       host_name;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random short stalls, plus one long hold per random phase
  initial begin
    int served;
    served = 0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_reqs != served) begin
        served = hold_reqs;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL ttl_lru_name_cache_unit");
      $finish;
    end
  end

  task automatic push_word(tlnc_pkg::func_t fn, logic [7:0] b, bit last, logic [31:0] addr,
                           logic [31:0] ttl, logic [31:0] now);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {now, ttl, addr, b};
    in_tuser <= fn;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_word(fn, b, last, addr, ttl, now);
  endtask

  // non-final words carry random operands, which the block must ignore
  task automatic send_op(tlnc_pkg::func_t fn, int idx, logic [31:0] addr, logic [31:0] ttl,
                         logic [31:0] now);
    if (name_len[idx] == 0) begin
      push_word(fn, 8'd0, 1'b1, addr, ttl, now);
    end else begin
      for (int i = 0; i < name_len[idx]; i++) begin
        if (i == name_len[idx] - 1)
          push_word(fn, names[idx][i], 1'b1, addr, ttl, now);
        else
          push_word(tlnc_pkg::func_t'($urandom_range(0, 3)), names[idx][i], 1'b0, $urandom,
                    $urandom, $urandom);
      end
    end
  endtask

  task automatic set_floor(logic [31:0] v);
    in_tvalid <= 1'b0;
    while (sb.want_found.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.ttl_floor = v;
  endtask

  task automatic random_phase(int count, int quiet_from);
    int              pick;
    tlnc_pkg::func_t fn;
    logic [31:0]     ttl;
    for (int n = 0; n < count; n++) begin
      if (n == quiet_from) quiet = 1'b1;
      if (n == count / 3) hold_reqs++;
      pick = $urandom_range(0, 99);
      if (pick < 45) fn = tlnc_pkg::FN_LOOKUP;
      else if (pick < 92) fn = tlnc_pkg::FN_INSERT;
      else if (pick < 96) fn = tlnc_pkg::FN_FLUSH;
      else fn = tlnc_pkg::FN_NOP;
      if ($urandom_range(0, 49) == 0) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, 3000);
      ttl = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 120);
      send_op(fn, $urandom_range(0, N_NAMES - 1), $urandom, ttl, now_ms);
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = tlnc_pkg::FN_LOOKUP;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    now_ms = 32'd1000;

    // random short names, then special ones: mixed case, empty, long pair differing only past the cut, odd bytes
    for (int k = 0; k < N_NAMES; k++) begin
      name_len[k] = $urandom_range(1, 4);
      for (int i = 0; i < name_len[k]; i++)
        names[k][i] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(8'h41, 8'h5A))
                                                    | ($urandom_range(0, 1) ?
                                                       tlnc_pkg::CASE_OFS : 8'h0);
    end
    host_name = "Www.Example";
    name_len[0] = host_name.len();
    for (int i = 0; i < host_name.len(); i++) names[0][i] = host_name[i];
    name_len[1] = 0;
    name_len[2] = 70;
    name_len[3] = 70;
    for (int i = 0; i < 70; i++) begin
      names[2][i] = 8'h41 + 8'(i % 26);
      names[3][i] = (i < 63) ? names[2][i] + tlnc_pkg::CASE_OFS : 8'h7A;
    end
    name_len[4] = 4;
    names[4][0] = 8'hFF; names[4][1] = 8'h00; names[4][2] = 8'h01; names[4][3] = 8'h5A;
    name_len[5] = 4;
    names[5][0] = 8'hFF; names[5][1] = 8'h01; names[5][2] = 8'h7A; names[5][3] = 8'h00;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(tlnc_pkg::FN_INSERT, 0, 32'hC0A80001, 32'd0, 32'd1000);
    send_op(tlnc_pkg::FN_LOOKUP, 0, 32'h0, 32'h0, 32'd2000);
    send_op(tlnc_pkg::FN_LOOKUP, 0, 32'h0, 32'h0, 32'd1000 + 32'd60000);
    send_op(tlnc_pkg::FN_INSERT, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd70000);
    send_op(tlnc_pkg::FN_LOOKUP, 0, 32'h0, 32'h0, 32'd70001);
    send_op(tlnc_pkg::FN_INSERT, 1, 32'h0A000001, 32'd5, 32'hFFFFFFF0);
    send_op(tlnc_pkg::FN_LOOKUP, 1, 32'h0, 32'h0, 32'hFFFFFFFF);
    send_op(tlnc_pkg::FN_INSERT, 2, 32'h01020304, 32'd100, 32'h0);
    send_op(tlnc_pkg::FN_LOOKUP, 3, 32'h0, 32'h0, 32'd10);
    send_op(tlnc_pkg::FN_INSERT, 4, 32'h00000000, 32'd1, 32'd20);
    send_op(tlnc_pkg::FN_LOOKUP, 5, 32'h0, 32'h0, 32'd30);
    send_op(tlnc_pkg::FN_NOP, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd40);
    send_op(tlnc_pkg::FN_FLUSH, 2, 32'h0, 32'h0, 32'd50);
    send_op(tlnc_pkg::FN_LOOKUP, 2, 32'h0, 32'h0, 32'd60);

    // fill the store with long-lived names so replacement runs
    for (int k = 6; k < N_NAMES; k++) begin
      now_ms = now_ms + 32'd7;
      send_op(tlnc_pkg::FN_INSERT, k, $urandom, 32'd1000, now_ms);
    end

    set_floor(32'd0);
    random_phase(40, -1);
    set_floor(32'hFFFFFFFF);
    random_phase(40, -1);
    set_floor(32'd1);
    random_phase(40, -1);
    set_floor($urandom);
    random_phase(40, -1);
    set_floor(32'd30);
    random_phase(55, 35);

    in_tvalid <= 1'b0;
    while (sb.want_found.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASS ttl_lru_name_cache_unit");
    else
      $display("FAIL ttl_lru_name_cache_unit");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tlnc_pkg.sv
rtl/ttl_lru_name_cache_unit.sv
bench/ttl_lru_name_cache_unit_tb.sv
